### sv/urfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package urfd_pkg;

  // Receive store geometry
  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int RX_LEVEL_W = 9;

  // Queue between front and back (power of two)
  localparam int QDEPTH  = 2;
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Status bits and characters
  localparam logic [7:0] STATUS_TX_READY = 8'h01;
  localparam logic [7:0] STATUS_RX_READY = 8'h02;
  localparam logic [7:0] CHAR_SUBST      = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CHAR_PRINT_LO   = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI   = 8'h7E;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [RX_LEVEL_W-1:0] rx_level_t;

  // Bus operation codes
  typedef enum logic [1:0] {
    FUNC_WR_DATA = 2'd0,
    FUNC_RD_DATA = 2'd1,
    FUNC_RD_STAT = 2'd2,
    FUNC_RX_BYTE = 2'd3
  } func_t;

  // Classified operation: data is the filtered tx char or the received byte
  typedef struct packed {
    func_t      func;
    logic [7:0] data;
  } urfd_op_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } bk_state_t;

  // Pointer advance with wrap at the store depth
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(FIFO_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // Transmit filter: newline and printable pass, everything else is '.'
  function automatic logic [7:0] tx_filter(input logic [7:0] b);
    logic [7:0] r;
    if (b == CHAR_NEWLINE) r = b;
    else if (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) r = b;
    else r = CHAR_SUBST;
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/uart_rx_fifo_device.sv
`timescale 1ns / 1ps
`default_nettype none

// UART model with a receive FIFO. Each input beat is a data write (emits a
// filtered transmit char), a data read (pops the oldest received byte, 0 when
// empty), a status read (bit0 tx ready, bit1 rx data present) or a received
// byte (pushed; a full FIFO drops its oldest byte). Every beat gives exactly
// one result beat carrying the FIFO level after the operation. A beat enters
// a two-entry queue and its result is registered in the result register; a
// read of a non-empty FIFO also passes through the registered read port of
// the receive store. Sustained rate is one beat per cycle while the output
// is not stalled; a data read that finds data holds off the next beat.
module uart_rx_fifo_device (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_func,
  input  wire logic [7:0]           in_byte_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_read_value,
  output logic                      out_tx_valid,
  output logic [7:0]                out_tx_char,
  output urfd_pkg::rx_level_t       out_rx_level
);
  import urfd_pkg::*;

  logic     q_push, q_full, q_pop, q_valid;
  urfd_op_t q_push_op, q_op;

  // Accept and classify
  urfd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_byte_in (in_byte_in),
    .q_push     (q_push),
    .q_push_op  (q_push_op),
    .q_full     (q_full)
  );

  // Decoupling queue
  urfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  // FIFO state and results
  urfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_op           (q_op),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_tx_valid   (out_tx_valid),
    .out_tx_char    (out_tx_char),
    .out_rx_level   (out_rx_level)
  );

endmodule

`default_nettype wire

### sv/urfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module urfd_front (
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      in_func,
  input  wire logic [7:0]      in_byte_in,
  output logic                 q_push,
  output urfd_pkg::urfd_op_t   q_push_op,
  input  wire logic            q_full
);
  import urfd_pkg::*;

  func_t func;

  // Accept a beat whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign func     = func_t'(in_func);

  // Classify: transmit bytes are filtered here, received bytes pass raw
  always_comb begin
    q_push_op.func = func;
    unique case (func)
      FUNC_WR_DATA: q_push_op.data = tx_filter(in_byte_in);
      FUNC_RX_BYTE: q_push_op.data = in_byte_in;
      default:      q_push_op.data = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/urfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module urfd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire urfd_pkg::urfd_op_t push_op,
  output logic                    full,
  input  wire logic               pop,
  output logic                    q_valid,
  output urfd_pkg::urfd_op_t      q_op
);
  import urfd_pkg::*;

  urfd_op_t           entry_r [QDEPTH];
  logic [QIDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [QIDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_op    = entry_r[rd_idx_r];

  // Index and count update; indexes wrap naturally (depth is a power of two)
  always_comb begin
    wr_idx_nxt = push ? wr_idx_r + 1'b1 : wr_idx_r;
    rd_idx_nxt = pop  ? rd_idx_r + 1'b1 : rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_idx_r] <= push_op;
  end

endmodule

`default_nettype wire

### sv/urfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module urfd_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire urfd_pkg::urfd_op_t   q_op,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_read_value,
  output logic                      out_tx_valid,
  output logic [7:0]                out_tx_char,
  output urfd_pkg::rx_level_t       out_rx_level
);
  import urfd_pkg::*;

  bk_state_t  state_r, state_nxt;
  ptr_t       wr_ptr_r, wr_ptr_nxt;
  ptr_t       rd_ptr_r, rd_ptr_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [7:0] mem_r [FIFO_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we, mem_re;
  logic       out_free, load;
  logic       has_data;

  // Result register
  logic       out_valid_r;
  logic [7:0] read_value_r, read_value_nxt;
  logic       tx_valid_r, tx_valid_nxt;
  logic [7:0] tx_char_r, tx_char_nxt;
  rx_level_t  rx_level_r, rx_level_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign has_data = (cnt_r != '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free && q_op.func == FUNC_RD_DATA && has_data) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Execute: pointer, count, store and result control
  always_comb begin
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    load           = 1'b0;
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    cnt_nxt        = cnt_r;
    read_value_nxt = '0;
    tx_valid_nxt   = 1'b0;
    tx_char_nxt    = '0;
    rx_level_nxt   = rx_level_t'(cnt_r);
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_op.func)
            FUNC_WR_DATA: begin
              load         = 1'b1;
              tx_valid_nxt = 1'b1;
              tx_char_nxt  = q_op.data;
            end
            FUNC_RD_DATA: begin
              if (has_data) begin
                // store read is registered; result is loaded from the read state
                mem_re     = 1'b1;
                rd_ptr_nxt = ptr_next(rd_ptr_r);
                cnt_nxt    = cnt_r - 1'b1;
              end else begin
                load = 1'b1;
              end
            end
            FUNC_RD_STAT: begin
              load           = 1'b1;
              read_value_nxt = has_data ? (STATUS_TX_READY | STATUS_RX_READY)
                                        : STATUS_TX_READY;
            end
            FUNC_RX_BYTE: begin
              load       = 1'b1;
              mem_we     = 1'b1;
              wr_ptr_nxt = ptr_next(wr_ptr_r);
              // full store drops the oldest byte
              if (cnt_r == cnt_t'(FIFO_DEPTH)) rd_ptr_nxt = ptr_next(rd_ptr_r);
              else cnt_nxt = cnt_r + 1'b1;
              rx_level_nxt = rx_level_t'(cnt_nxt);
            end
            default: load = 1'b0;
          endcase
        end
      end
      BK_READ: begin
        if (out_free) begin
          load           = 1'b1;
          read_value_nxt = rd_data_r;
        end
      end
      default: load = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      read_value_r <= read_value_nxt;
      tx_valid_r   <= tx_valid_nxt;
      tx_char_r    <= tx_char_nxt;
      rx_level_r   <= rx_level_nxt;
    end
  end

  // Receive store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem_r[wr_ptr_r] <= q_op.data;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem_r[rd_ptr_r];
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = read_value_r;
  assign out_tx_valid   = tx_valid_r;
  assign out_tx_char    = tx_char_r;
  assign out_rx_level   = rx_level_r;

endmodule

`default_nettype wire
